// ===== rtl/srtm_pkg.sv =====
// shared types and constants of the spi register transaction master
// no dependencies; used by the channel interfaces and the top level
package srtm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_READ_FLAG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_READ_FLAG  = 1'd1;

    localparam logic [7:0] SINGLE_READ_FLAG_RST = 8'h80;
    localparam logic [7:0] BURST_READ_FLAG_RST  = 8'hC0;

    // command codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // filler byte shifted out during a read
    localparam logic [7:0] READ_FILL_BYTE = 8'h00;
    localparam logic [2:0] LAST_BIT_IDX   = 3'd7;

    // bus phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_SHIFT = 3'b010,
        PH_CLOSE = 3'b100
    } t_phase;

    // one tick with an optional command
    typedef struct packed {
        logic [1:0] operation;
        logic       target;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic [7:0] byte_count;
        logic       miso_level;
    } t_cmd;

    // pin levels and read data after one tick
    typedef struct packed {
        logic       sck_level;
        logic       mosi_level;
        logic       select_first_n;
        logic       select_second_n;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       last_byte;
        logic       busy_res;
    } t_rsp;

endpackage

// ===== rtl/srtm_cmd_if.sv =====
// valid/ready channel carrying tick and command transfers
// depends on srtm_pkg
interface srtm_cmd_if;
    import srtm_pkg::*;

    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/srtm_rsp_if.sv =====
// valid/ready channel carrying pin level and read data transfers
// depends on srtm_pkg
interface srtm_rsp_if;
    import srtm_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/spi_register_transaction_master_unit.sv =====
// spi mode-3 register transaction master for two slaves, msb first
// depends on srtm_pkg, srtm_cmd_if and srtm_rsp_if
//
// latency: each accepted tick's result is registered in the output register
// throughput: one tick per cycle while the result side takes every transfer;
//   the output register is the only stage, refilled in the cycle it drains
// reset: synchronous active low; bus idle, clock and selects high, mosi low,
//   read flags 0x80 and 0xC0, output register empty
module spi_register_transaction_master_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    srtm_cmd_if.sink                           i_cmd,
    srtm_rsp_if.source                         o_rsp,
    input  logic                               i_cfg_we,
    input  logic [srtm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [srtm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import srtm_pkg::*;

    // configuration registers
    logic [7:0] r_single_flag;
    logic [7:0] r_burst_flag;

    // bus state
    t_phase     r_phase,    n_phase;
    logic       r_target,   n_target;
    logic       r_is_read,  n_is_read;
    logic       r_send_adr, n_send_adr;
    logic [7:0] r_out_sh,   n_out_sh;
    logic [7:0] r_in_sh,    n_in_sh;
    logic [7:0] r_wr_byte,  n_wr_byte;
    logic [2:0] r_bit_idx,  n_bit_idx;
    logic       r_half,     n_half;
    logic [7:0] r_left,     n_left;
    logic       r_sck,      n_sck;
    logic       r_mosi,     n_mosi;
    logic       r_sel0,     n_sel0;
    logic       r_sel1,     n_sel1;

    // output register
    logic       r_rsp_vld;
    t_rsp       r_rsp;
    t_rsp       n_rsp;

    logic       accept;
    logic       emit_valid;
    logic       emit_last;
    logic [7:0] emit_byte;
    logic [7:0] sh_in;
    logic [7:0] left_dec;

    assign i_cmd.ready = !r_rsp_vld || o_rsp.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign sh_in    = {r_in_sh[6:0], i_cmd.payload.miso_level};
    assign left_dec = (r_left != 8'd0) ? (r_left - 8'd1) : r_left;

    // next bus state for one tick
    always_comb begin
        n_phase    = r_phase;
        n_target   = r_target;
        n_is_read  = r_is_read;
        n_send_adr = r_send_adr;
        n_out_sh   = r_out_sh;
        n_in_sh    = r_in_sh;
        n_wr_byte  = r_wr_byte;
        n_bit_idx  = r_bit_idx;
        n_half     = r_half;
        n_left     = r_left;
        n_sck      = r_sck;
        n_mosi     = r_mosi;
        n_sel0     = r_sel0;
        n_sel1     = r_sel1;
        emit_valid = 1'b0;
        emit_last  = 1'b0;
        emit_byte  = 8'd0;
        case (r_phase)
            PH_SHIFT: begin
                if (!r_half) begin
                    // falling edge, drive mosi
                    n_sck  = 1'b0;
                    n_mosi = r_out_sh[7];
                    n_half = 1'b1;
                end else begin
                    // rising edge, sample miso
                    n_sck    = 1'b1;
                    n_in_sh  = sh_in;
                    n_out_sh = {r_out_sh[6:0], 1'b0};
                    n_half   = 1'b0;
                    if (r_bit_idx == LAST_BIT_IDX) begin
                        n_bit_idx = 3'd0;
                        // byte boundary
                        if (r_send_adr) begin
                            n_send_adr = 1'b0;
                            if (!r_is_read) begin
                                n_out_sh = r_wr_byte;
                            end else if (r_left == 8'd0) begin
                                n_phase = PH_CLOSE;
                            end else begin
                                n_out_sh = READ_FILL_BYTE;
                            end
                        end else if (r_is_read) begin
                            emit_valid = 1'b1;
                            emit_byte  = sh_in;
                            n_left     = left_dec;
                            if (left_dec == 8'd0) begin
                                emit_last = 1'b1;
                                n_phase   = PH_CLOSE;
                            end else begin
                                n_out_sh = READ_FILL_BYTE;
                            end
                        end else begin
                            n_phase = PH_CLOSE;
                        end
                    end else begin
                        n_bit_idx = r_bit_idx + 3'd1;
                    end
                end
            end
            PH_CLOSE: begin
                n_sel0  = 1'b1;
                n_sel1  = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                // idle, and any unused phase code
                n_phase = PH_IDLE;
                if (i_cmd.payload.operation == OP_WRITE ||
                    i_cmd.payload.operation == OP_READ) begin
                    n_target   = i_cmd.payload.target;
                    n_is_read  = (i_cmd.payload.operation == OP_READ);
                    n_send_adr = 1'b1;
                    n_wr_byte  = i_cmd.payload.write_data;
                    if (i_cmd.payload.operation == OP_READ) begin
                        n_out_sh = i_cmd.payload.reg_address |
                                   ((i_cmd.payload.byte_count > 8'd1) ?
                                    r_burst_flag : r_single_flag);
                        n_left   = i_cmd.payload.byte_count;
                    end else begin
                        n_out_sh = i_cmd.payload.reg_address;
                        n_left   = 8'd0;
                    end
                    n_bit_idx = 3'd0;
                    n_half    = 1'b0;
                    n_phase   = PH_SHIFT;
                    n_sck     = 1'b1;
                    n_sel0    = i_cmd.payload.target;
                    n_sel1    = !i_cmd.payload.target;
                end
            end
        endcase
    end

    // result of the tick
    always_comb begin
        n_rsp.sck_level       = n_sck;
        n_rsp.mosi_level      = n_mosi;
        n_rsp.select_first_n  = n_sel0;
        n_rsp.select_second_n = n_sel1;
        n_rsp.read_valid      = emit_valid;
        n_rsp.read_byte       = emit_byte;
        n_rsp.last_byte       = emit_last;
        n_rsp.busy_res        = (n_phase != PH_IDLE);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_flag <= SINGLE_READ_FLAG_RST;
            r_burst_flag  <= BURST_READ_FLAG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SINGLE_READ_FLAG: r_single_flag <= i_cfg_data;
                CFG_BURST_READ_FLAG:  r_burst_flag  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // bus state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_target   <= 1'b0;
            r_is_read  <= 1'b0;
            r_send_adr <= 1'b0;
            r_out_sh   <= 8'd0;
            r_in_sh    <= 8'd0;
            r_wr_byte  <= 8'd0;
            r_bit_idx  <= 3'd0;
            r_half     <= 1'b0;
            r_left     <= 8'd0;
            r_sck      <= 1'b1;
            r_mosi     <= 1'b0;
            r_sel0     <= 1'b1;
            r_sel1     <= 1'b1;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_target   <= n_target;
            r_is_read  <= n_is_read;
            r_send_adr <= n_send_adr;
            r_out_sh   <= n_out_sh;
            r_in_sh    <= n_in_sh;
            r_wr_byte  <= n_wr_byte;
            r_bit_idx  <= n_bit_idx;
            r_half     <= n_half;
            r_left     <= n_left;
            r_sck      <= n_sck;
            r_mosi     <= n_mosi;
            r_sel0     <= n_sel0;
            r_sel1     <= n_sel1;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else if (accept) begin
            r_rsp_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_vld <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_vld;
    assign o_rsp.payload = r_rsp;

endmodule
